// ===== design/lru_block_buffer_pool_defines.svh =====
// ----------------------------------------------------------------------------
// lru_block_buffer_pool_defines
// Assertion macros used by the buffer pool top level.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_POOL_DEFINES_SVH
`define LRU_BLOCK_BUFFER_POOL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Types and constants of the LRU block buffer pool.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int FUNC_W    = 2;
    localparam int FILE_W    = 8;
    localparam int OFF_W     = 16;
    localparam int SIDX_W    = 4;
    localparam int OSLOT_W   = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_ACCESS = 2'd0,
        FN_WRITE  = 2'd1,
        FN_ALLOC  = 2'd2,
        FN_INVAL  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic look;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

endpackage

// ===== design/lbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: capture, lookup, update. Update waits for a free output register.
// ----------------------------------------------------------------------------
module lbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_stall,
    input  lbp_pkg::t_stat i_stat,
    output lbp_pkg::t_cmd  o_cmd,
    output logic          o_stall
);
    import lbp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign out_free = !i_stat.out_full || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    o_stall      = 1'b0;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_LOOK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lbp_datapath.sv =====
// ----------------------------------------------------------------------------
// lbp_datapath
// Tag store, valid/dirty bits, recency ranks, lookup registers and output
// register of the buffer pool.
// ----------------------------------------------------------------------------
module lbp_datapath #(
    parameter int SLOTS = lbp_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbp_pkg::t_cmd                i_cmd,
    output lbp_pkg::t_stat               o_stat,
    input  logic [lbp_pkg::FUNC_W-1:0]   i_func,
    input  logic [lbp_pkg::FILE_W-1:0]   i_file_id,
    input  logic [lbp_pkg::OFF_W-1:0]    i_block_offset,
    input  logic [lbp_pkg::SIDX_W-1:0]   i_slot_index,
    input  logic                         i_out_stall,
    output logic                         o_valid,
    output logic [lbp_pkg::OSLOT_W-1:0]  o_slot,
    output logic                         o_hit,
    output logic                         o_writeback_needed,
    output logic [lbp_pkg::FILE_W-1:0]   o_victim_file,
    output logic [lbp_pkg::OFF_W-1:0]    o_victim_offset
);
    import lbp_pkg::*;

    localparam int SW = $clog2(SLOTS);
    typedef logic [SW-1:0] t_idx;

    // captured request
    t_func               r_func;
    logic [FILE_W-1:0]   r_fid;
    logic [OFF_W-1:0]    r_off;
    logic [SIDX_W-1:0]   r_sidx;

    // pool state
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_dirty;
    logic [FILE_W-1:0]   r_file [SLOTS];
    logic [OFF_W-1:0]    r_offs [SLOTS];
    t_idx                r_rank [SLOTS];

    // lookup results
    logic [SLOTS-1:0]    r_hit_oh, r_inv_oh, r_lru_oh, r_wr_oh;
    logic                r_hit_any, r_inv_any, r_ex_any;
    t_idx                r_hit_rank, r_inv_rank, r_ex_rank, r_wr_rank;
    logic [SLOTS-1:0]    n_hit_oh, n_inv_oh, n_lru_oh, n_wr_oh;
    logic                n_hit_any, n_inv_any, n_ex_any;
    t_idx                n_hit_rank, n_inv_rank, n_ex_rank, n_wr_rank;
    logic [SLOTS-1:0]    ex_by_rank;

    // output word
    logic                r_out_valid;
    logic [OSLOT_W-1:0]  r_o_slot;
    logic                r_o_hit;
    logic                r_o_wb;
    logic [FILE_W-1:0]   r_o_vf;
    logic [OFF_W-1:0]    r_o_vo;
    logic [OSLOT_W-1:0]  n_o_slot;
    logic                n_o_wb;
    logic [FILE_W-1:0]   n_o_vf;
    logic [OFF_W-1:0]    n_o_vo;

    // update controls
    logic [SLOTS-1:0]    ex_oh, sel;
    t_idx                tgt_rank, sel_idx;
    logic                do_fill, do_mark, do_clear, new_dirty;
    logic                vic_dirty;
    logic [FILE_W-1:0]   vic_file;
    logic [OFF_W-1:0]    vic_off;

    // ---------------- lookup ----------------
    always_comb begin
        n_hit_oh   = '0;
        n_hit_any  = 1'b0;
        ex_by_rank = '0;
        n_lru_oh   = '0;
        n_wr_oh    = '0;
        n_ex_any   = 1'b0;
        n_ex_rank  = '0;
        n_hit_rank = '0;
        n_inv_rank = '0;
        n_wr_rank  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_valid[i] && r_offs[i] == r_off && r_file[i] == r_fid) begin
                n_hit_oh    = '0;
                n_hit_oh[i] = 1'b1;
                n_hit_any   = 1'b1;
            end
            if (r_file[i] != r_fid) begin
                ex_by_rank[r_rank[i]] = 1'b1;
            end
            n_lru_oh[i] = (r_rank[i] == t_idx'(SLOTS - 1));
            n_wr_oh[i]  = (int'(r_sidx) == i);
        end
        n_inv_oh  = ~r_valid & (r_valid + SLOTS'(1));
        n_inv_any = ~&r_valid;
        for (int r = 0; r < SLOTS; r++) begin
            if (ex_by_rank[r]) begin
                n_ex_any  = 1'b1;
                n_ex_rank = t_idx'(r);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            n_hit_rank = n_hit_rank | (n_hit_oh[i] ? r_rank[i] : '0);
            n_inv_rank = n_inv_rank | (n_inv_oh[i] ? r_rank[i] : '0);
            n_wr_rank  = n_wr_rank  | (n_wr_oh[i]  ? r_rank[i] : '0);
        end
    end

    // ---------------- victim select and update ----------------
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            ex_oh[i] = (r_rank[i] == r_ex_rank);
        end
        sel       = '0;
        tgt_rank  = '0;
        do_fill   = 1'b0;
        do_mark   = 1'b0;
        do_clear  = 1'b0;
        new_dirty = 1'b0;
        case (r_func)
            FN_ACCESS: begin
                if (r_hit_any) begin
                    sel      = r_hit_oh;
                    tgt_rank = r_hit_rank;
                end else if (r_inv_any) begin
                    sel      = r_inv_oh;
                    tgt_rank = r_inv_rank;
                    do_fill  = 1'b1;
                end else if (r_ex_any) begin
                    sel      = ex_oh;
                    tgt_rank = r_ex_rank;
                    do_fill  = 1'b1;
                end else begin
                    sel      = r_lru_oh;
                    tgt_rank = t_idx'(SLOTS - 1);
                    do_fill  = 1'b1;
                end
            end
            FN_WRITE: begin
                sel      = r_wr_oh;
                tgt_rank = r_wr_rank;
                do_mark  = 1'b1;
            end
            FN_ALLOC: begin
                do_fill   = 1'b1;
                new_dirty = 1'b1;
                if (r_inv_any) begin
                    sel      = r_inv_oh;
                    tgt_rank = r_inv_rank;
                end else begin
                    sel      = r_lru_oh;
                    tgt_rank = t_idx'(SLOTS - 1);
                end
            end
            FN_INVAL: begin
                do_clear = 1'b1;
            end
            default: begin
                do_clear = 1'b0;
            end
        endcase

        sel_idx  = '0;
        vic_file = '0;
        vic_off  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (sel[i]) begin
                sel_idx  = sel_idx | t_idx'(i);
                vic_file = vic_file | r_file[i];
                vic_off  = vic_off | r_offs[i];
            end
        end
        vic_dirty = |(sel & r_valid & r_dirty);
        n_o_wb    = do_fill && vic_dirty;
        n_o_vf    = n_o_wb ? vic_file : '0;
        n_o_vo    = n_o_wb ? vic_off : '0;
        case (r_func)
            FN_WRITE: n_o_slot = OSLOT_W'(r_sidx);
            FN_INVAL: n_o_slot = '0;
            default:  n_o_slot = OSLOT_W'(sel_idx);
        endcase
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= t_idx'(i);
            end
        end else begin
            if (i_cmd.update) begin
                if (do_clear) begin
                    r_valid <= '0;
                    r_dirty <= '0;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (sel[i] && do_fill) begin
                        r_valid[i] <= 1'b1;
                        r_dirty[i] <= new_dirty;
                    end
                    if (sel[i] && do_mark) begin
                        r_dirty[i] <= 1'b1;
                    end
                    if (|sel) begin
                        if (sel[i]) begin
                            r_rank[i] <= '0;
                        end else if (r_rank[i] < tgt_rank) begin
                            r_rank[i] <= r_rank[i] + t_idx'(1);
                        end
                    end
                end
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_fid  <= i_file_id;
            r_off  <= i_block_offset;
            r_sidx <= i_slot_index;
        end
        if (i_cmd.look) begin
            r_hit_oh   <= n_hit_oh;
            r_hit_any  <= n_hit_any;
            r_hit_rank <= n_hit_rank;
            r_inv_oh   <= n_inv_oh;
            r_inv_any  <= n_inv_any;
            r_inv_rank <= n_inv_rank;
            r_ex_any   <= n_ex_any;
            r_ex_rank  <= n_ex_rank;
            r_lru_oh   <= n_lru_oh;
            r_wr_oh    <= n_wr_oh;
            r_wr_rank  <= n_wr_rank;
        end
        if (i_cmd.update) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (sel[i] && do_fill) begin
                    r_file[i] <= r_fid;
                    r_offs[i] <= r_off;
                end
            end
            r_o_slot <= n_o_slot;
            r_o_hit  <= (r_func == FN_ACCESS) && r_hit_any;
            r_o_wb   <= n_o_wb;
            r_o_vf   <= n_o_vf;
            r_o_vo   <= n_o_vo;
        end
    end

    assign o_stat.out_full    = r_out_valid;
    assign o_valid            = r_out_valid;
    assign o_slot             = r_o_slot;
    assign o_hit              = r_o_hit;
    assign o_writeback_needed = r_o_wb;
    assign o_victim_file      = r_o_vf;
    assign o_victim_offset    = r_o_vo;

endmodule

// ===== design/lru_block_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_pool
// Tag and LRU replacement logic of a fully associative block buffer pool.
// ----------------------------------------------------------------------------
// Each accepted request passes a lookup state, then an update state. The
// lookup compares the tag against every slot in parallel and reduces the
// recency ranks to the replacement candidates; the update selects the victim,
// updates tags, flags and ranks and loads the output register. A new word is
// taken in the update state, not during lookup; the output register holds
// a result while the downstream side stalls, and the update waits only while
// that register is full and stalled. Invalidate passes through the same states.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_pool_defines.svh"

module lru_block_buffer_pool #(
    parameter int SLOTS = lbp_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lbp_pkg::FUNC_W-1:0]   i_func,
    input  logic [lbp_pkg::FILE_W-1:0]   i_file_id,
    input  logic [lbp_pkg::OFF_W-1:0]    i_block_offset,
    input  logic [lbp_pkg::SIDX_W-1:0]   i_slot_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lbp_pkg::OSLOT_W-1:0]  o_slot,
    output logic                         o_hit,
    output logic                         o_writeback_needed,
    output logic [lbp_pkg::FILE_W-1:0]   o_victim_file,
    output logic [lbp_pkg::OFF_W-1:0]    o_victim_offset
);
    import lbp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    lbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_stall     (o_stall)
    );

    lbp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_func             (i_func),
        .i_file_id          (i_file_id),
        .i_block_offset     (i_block_offset),
        .i_slot_index       (i_slot_index),
        .i_out_stall        (i_stall),
        .o_valid            (o_valid),
        .o_slot             (o_slot),
        .o_hit              (o_hit),
        .o_writeback_needed (o_writeback_needed),
        .o_victim_file      (o_victim_file),
        .o_victim_offset    (o_victim_offset)
    );

    `LBP_ASSERT_NXT(a_accept_to_look, i_valid && !o_stall, w_cmd.look, "accepted word skipped lookup")
    `LBP_ASSERT_IMP(a_look_blocks, w_cmd.look, !w_cmd.update && o_stall, "lookup overlapped update")
    `LBP_ASSERT_NXT(a_update_shows, w_cmd.update, o_valid, "update did not present a word")
    `LBP_ASSERT_IMP(a_wb_not_hit, o_valid && o_writeback_needed, !o_hit, "writeback on a hit")

endmodule
